### hw/rtl/lsbe_pkg.sv
// Package for the LED strip bit encoder: shared types and constants.
// No dependencies; every other file in hw/rtl imports it.
package lsbe_pkg;

   localparam int CHANNEL_WIDTH   = 8;
   localparam int CHANNEL_COUNT   = 3;
   localparam int WORD_WIDTH      = CHANNEL_WIDTH * CHANNEL_COUNT;
   localparam int TICK_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam int BIT_COUNT_WIDTH = $clog2(WORD_WIDTH + 1);

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIM_DIVISOR      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_HIGH_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_HIGH_TICKS   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD_TICKS = 2'd3;

   localparam logic [7:0] RESET_DIM_DIVISOR      = 8'd1;
   localparam logic [7:0] RESET_ZERO_HIGH_TICKS  = 8'd4;
   localparam logic [7:0] RESET_ONE_HIGH_TICKS   = 8'd10;
   localparam logic [7:0] RESET_BIT_PERIOD_TICKS = 8'd20;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_HOLD
   } front_state_type;

   // dimmed pixel, G R B from the top bit down
   typedef struct packed {
      logic                  frame_end;
      logic [WORD_WIDTH-1:0] word;
   } pixel_word_type;

   // queue head as seen by the serialiser
   typedef struct packed {
      logic           valid;
      pixel_word_type data;
   } queue_head_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] zero_high;
      logic [TICK_WIDTH-1:0] one_high;
      logic [TICK_WIDTH-1:0] period;
   } line_timing_type;

endpackage

### hw/rtl/lsbe_front.sv
// Front end: takes a pixel request and divides each channel by the dim divisor.
// Three restoring dividers run side by side, one quotient bit per cycle. Uses lsbe_pkg.
module lsbe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lsbe_pkg::WORD_WIDTH-1:0] in_pixel,    // red, green, blue
   input  logic                          in_frame_end,
   input  logic [lsbe_pkg::CHANNEL_WIDTH-1:0] dim_divisor,
   output logic                          out_valid,
   input  logic                          out_ready,
   output lsbe_pkg::pixel_word_type      out_data
);
   import lsbe_pkg::*;

   localparam int STEP_WIDTH = $clog2(CHANNEL_WIDTH);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(CHANNEL_WIDTH - 1);

   front_state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [CHANNEL_WIDTH-1:0] divisor_ff, divisor_in;
   logic                     frame_ff, frame_in;
   logic [CHANNEL_WIDTH-1:0] quot_ff [CHANNEL_COUNT];
   logic [CHANNEL_WIDTH-1:0] quot_in [CHANNEL_COUNT];
   logic [CHANNEL_WIDTH-1:0] rem_ff  [CHANNEL_COUNT];
   logic [CHANNEL_WIDTH-1:0] rem_in  [CHANNEL_COUNT];
   logic [CHANNEL_WIDTH:0]   trial   [CHANNEL_COUNT];
   logic                     fits    [CHANNEL_COUNT];

   assign in_ready  = (state_ff == FRONT_IDLE);
   assign out_valid = (state_ff == FRONT_HOLD);
   // lanes: 0 red, 1 green, 2 blue; sent green first
   assign out_data.frame_end = frame_ff;
   assign out_data.word      = {quot_ff[1], quot_ff[0], quot_ff[2]};

   always_comb begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         trial[i] = {rem_ff[i], quot_ff[i][CHANNEL_WIDTH-1]};
         fits[i]  = (trial[i] >= {1'b0, divisor_ff});
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      frame_in   = frame_ff;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         quot_in[i] = quot_ff[i];
         rem_in[i]  = rem_ff[i];
      end
      case (state_ff)
         FRONT_IDLE: begin
            if (in_valid) begin
               state_in = FRONT_DIVIDE;
               step_in  = '0;
               frame_in = in_frame_end;
               // a zero divisor behaves as one
               divisor_in = (dim_divisor == '0) ? CHANNEL_WIDTH'(1) : dim_divisor;
               for (int i = 0; i < CHANNEL_COUNT; i++) begin
                  quot_in[i] = in_pixel[i*CHANNEL_WIDTH +: CHANNEL_WIDTH];
                  rem_in[i]  = '0;
               end
            end
         end
         FRONT_DIVIDE: begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
               quot_in[i] = {quot_ff[i][CHANNEL_WIDTH-2:0], fits[i]};
               rem_in[i]  = fits[i] ? CHANNEL_WIDTH'(trial[i] - {1'b0, divisor_ff})
                                    : trial[i][CHANNEL_WIDTH-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = FRONT_HOLD;
            end
         end
         FRONT_HOLD: begin
            if (out_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      frame_ff   <= frame_in;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         quot_ff[i] <= quot_in[i];
         rem_ff[i]  <= rem_in[i];
      end
   end

endmodule

### hw/rtl/lsbe_queue.sv
// Short queue of dimmed pixel words between the divider and the serialiser.
// Register based, depth set by a parameter. Uses lsbe_pkg.
module lsbe_queue #(
   parameter int Depth = lsbe_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  lsbe_pkg::pixel_word_type push_data,
   input  logic                     pop,
   output lsbe_pkg::queue_head_type head
);
   import lsbe_pkg::*;

   localparam int PTR_WIDTH = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_WIDTH = $clog2(Depth + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(Depth - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT  = CNT_WIDTH'(Depth);

   pixel_word_type        entry_ff [Depth];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/lsbe_back.sv
// Back end: shifts a pixel word out MSB first, one bit per cycle while responses are accepted, with line timing.
// Drives the registered response fields. Uses lsbe_pkg.
module lsbe_back (
   input  logic                            clock,
   input  logic                            reset,
   input  lsbe_pkg::queue_head_type        head,
   output logic                            pop,
   input  lsbe_pkg::line_timing_type       timing,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            out_bit,
   output logic [lsbe_pkg::TICK_WIDTH-1:0] out_high,
   output logic [lsbe_pkg::TICK_WIDTH-1:0] out_low,
   output logic                            out_pixel_last,
   output logic                            out_frame_last
);
   import lsbe_pkg::*;

   localparam logic [BIT_COUNT_WIDTH-1:0] FIRST_LEFT = BIT_COUNT_WIDTH'(WORD_WIDTH - 1);

   logic [WORD_WIDTH-1:0]      word_ff, word_in;
   logic [BIT_COUNT_WIDTH-1:0] left_ff, left_in;
   logic                       frame_ff, frame_in;
   logic                       valid_ff, valid_in;
   logic                       bit_ff, bit_in;
   logic [TICK_WIDTH-1:0]      high_ff, high_in;
   logic [TICK_WIDTH-1:0]      low_ff, low_in;
   logic                       plast_ff, plast_in;
   logic                       flast_ff, flast_in;

   logic [WORD_WIDTH-1:0] src_word;
   logic                  src_frame;
   logic                  have_bit, advance, last_bit;
   logic [TICK_WIDTH-1:0] raw_high;

   assign out_valid      = valid_ff;
   assign out_bit        = bit_ff;
   assign out_high       = high_ff;
   assign out_low        = low_ff;
   assign out_pixel_last = plast_ff;
   assign out_frame_last = flast_ff;

   always_comb begin
      // with nothing left in flight, the queue head supplies the first bit directly
      src_word  = (left_ff == '0) ? head.data.word : word_ff;
      src_frame = (left_ff == '0) ? head.data.frame_end : frame_ff;
      have_bit  = (left_ff != '0) || head.valid;
      advance   = have_bit && (!valid_ff || out_ready);
      pop       = advance && (left_ff == '0);
      last_bit  = (left_ff == BIT_COUNT_WIDTH'(1));
      raw_high  = src_word[WORD_WIDTH-1] ? timing.one_high : timing.zero_high;

      word_in  = word_ff;
      left_in  = left_ff;
      frame_in = frame_ff;
      bit_in   = bit_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      plast_in = plast_ff;
      flast_in = flast_ff;
      valid_in = valid_ff && !out_ready;

      if (advance) begin
         valid_in = 1'b1;
         word_in  = {src_word[WORD_WIDTH-2:0], 1'b0};
         left_in  = (left_ff == '0) ? FIRST_LEFT : left_ff - 1'b1;
         frame_in = src_frame;
         bit_in   = src_word[WORD_WIDTH-1];
         high_in  = (raw_high == '0) ? TICK_WIDTH'(1) : raw_high;
         low_in   = (timing.period > high_in) ? timing.period - high_in : TICK_WIDTH'(1);
         plast_in = last_bit;
         flast_in = last_bit && src_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      frame_ff <= frame_in;
      bit_ff   <= bit_in;
      high_ff  <= high_in;
      low_ff   <= low_in;
      plast_ff <= plast_in;
      flast_ff <= flast_in;
   end

endmodule

### hw/rtl/led_strip_bit_encoder_core.sv
// LED strip bit encoder, top level: configuration registers, divider front end,
// pixel queue and bit serialiser. Depends on lsbe_pkg, lsbe_front, lsbe_queue, lsbe_back.
// A request passes the divider front end and the queue before the serialiser registers its first bit.
// Pixel rate is set by the serialiser emitting one bit a cycle while rsp_tready allows;
// the divider overlaps with the serialiser through the queue.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module led_strip_bit_encoder_core #(
   parameter int QueueDepth = lsbe_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // red, green, blue
   input  logic                                 req_tlast,  // frame_end
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,  // bit_value, high_ticks, low_ticks, zeros
   output logic                                 rsp_tuser,  // pixel_last
   output logic                                 rsp_tlast,  // frame_last
   input  logic                                 csr_we,
   input  logic [lsbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                           csr_wdata
);
   import lsbe_pkg::*;

   logic [7:0] dim_ff, zero_high_ff, one_high_ff, period_ff;

   logic                  front_valid, front_ready;
   pixel_word_type        front_data;
   queue_head_type        head;
   logic                  pop;
   line_timing_type       timing;
   logic                  out_bit;
   logic [TICK_WIDTH-1:0] out_high, out_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= RESET_DIM_DIVISOR;
         zero_high_ff <= RESET_ZERO_HIGH_TICKS;
         one_high_ff  <= RESET_ONE_HIGH_TICKS;
         period_ff    <= RESET_BIT_PERIOD_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIM_DIVISOR:      dim_ff       <= csr_wdata;
            CSR_ZERO_HIGH_TICKS:  zero_high_ff <= csr_wdata;
            CSR_ONE_HIGH_TICKS:   one_high_ff  <= csr_wdata;
            CSR_BIT_PERIOD_TICKS: period_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign timing.zero_high = zero_high_ff;
   assign timing.one_high  = one_high_ff;
   assign timing.period    = period_ff;

   lsbe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_pixel     (req_tdata),
      .in_frame_end (req_tlast),
      .dim_divisor  (dim_ff),
      .out_valid    (front_valid),
      .out_ready    (front_ready),
      .out_data     (front_data)
   );

   lsbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop        (pop),
      .head       (head)
   );

   lsbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .timing         (timing),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_bit        (out_bit),
      .out_high       (out_high),
      .out_low        (out_low),
      .out_pixel_last (rsp_tuser),
      .out_frame_last (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, out_low, out_high, out_bit};

endmodule
